/* hw/rtl/nbrd_pkg.sv */
// Shared constants for the background row decoder: nametable size,
// configuration register indexes and the fixed 64-entry NTSC color table.
// No dependencies.
package nbrd_pkg;

    // Nametable size in tiles
    localparam int TILES_WIDE = 32;
    localparam int TILES_HIGH = 30;

    // Field widths
    localparam int TILE_W   = 5;
    localparam int SUB_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int COLOR_W  = 6;
    localparam int PAL_W    = 48;
    localparam int RGB_W    = 24;
    localparam int REGIDX_W = 1;

    // Configuration register indexes
    localparam logic [REGIDX_W-1:0] REG_PALETTE_LOW  = 1'b0;
    localparam logic [REGIDX_W-1:0] REG_PALETTE_HIGH = 1'b1;

    // NTSC color table, {red, green, blue} per color id
    localparam logic [RGB_W-1:0] NTSC_RGB [64] = '{
        24'h808080, 24'h003DA6, 24'h0012B0, 24'h440096,
        24'hA1005E, 24'hC70028, 24'hBA0600, 24'h8C1700,
        24'h5C2F00, 24'h104500, 24'h054A00, 24'h00472E,
        24'h004166, 24'h000000, 24'h050505, 24'h050505,
        24'hC7C7C7, 24'h0077FF, 24'h2155FF, 24'h8237FA,
        24'hEB2FB5, 24'hFF2950, 24'hFF2200, 24'hD63200,
        24'hC46200, 24'h358000, 24'h058F00, 24'h008A55,
        24'h0099CC, 24'h212121, 24'h090909, 24'h090909,
        24'hFFFFFF, 24'h0FD7FF, 24'h69A2FF, 24'hD480FF,
        24'hFF45F3, 24'hFF618B, 24'hFF8833, 24'hFF9C12,
        24'hFABC20, 24'h9FE30E, 24'h2BF035, 24'h0CF0A4,
        24'h05FBFF, 24'h5E5E5E, 24'h0D0D0D, 24'h0D0D0D,
        24'hFFFFFF, 24'hA6FCFF, 24'hB3ECFF, 24'hDAABEB,
        24'hFFA8F9, 24'hFFABB3, 24'hFFD2B0, 24'hFFEFA6,
        24'hFFF79C, 24'hD7E895, 24'hA6EDAF, 24'hA2F2DA,
        24'h99FFFC, 24'hDDDDDD, 24'h111111, 24'h111111
    };

endpackage

/* hw/rtl/nes_background_row_decode.sv */
// Background row decoder top level: row register, pixel counter, palette
// registers and pixel output register. Depends on nbrd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per tile row: tile
//   column and row, pixel row in the tile, the two pattern plane bytes and
//   the attribute byte. Rows whose tile lies outside the nametable are
//   taken and dropped without output.
//   Output channel (out_valid/out_ready) gives eight pixel words per row,
//   leftmost pixel first, with last_pixel set on the eighth.
//   Configuration: cfg_write with cfg_index selects palette entries 0-7
//   (index 0) or 8-15 (index 1); write only while the block is idle.
// Timing:
//   A row is held in the row register; while the output register is free,
//   one pixel a cycle moves from it into the output register. A pixel counter
//   walks the row register, leftmost pixel first. The next row is taken in the
//   cycle its predecessor's last pixel moves out, so rows stream without
//   gaps.
// Reset: clears both palettes to zero and empties row and output registers.
// Stall: while out_ready is low with a word at the output, that word holds,
//   the pixel counter stops and in_ready stays low once a row is waiting.
module nes_background_row_decode
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_write,
    input  logic [nbrd_pkg::REGIDX_W-1:0]    cfg_index,
    input  logic [nbrd_pkg::PAL_W-1:0]       cfg_data,
    // input rows
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [nbrd_pkg::TILE_W-1:0]      tile_column,
    input  logic [nbrd_pkg::TILE_W-1:0]      tile_row,
    input  logic [nbrd_pkg::SUB_W-1:0]       row_in_tile,
    input  logic [nbrd_pkg::BYTE_W-1:0]      plane_low_byte,
    input  logic [nbrd_pkg::BYTE_W-1:0]      plane_high_byte,
    input  logic [nbrd_pkg::BYTE_W-1:0]      attribute_byte,
    // output pixels
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [nbrd_pkg::BYTE_W-1:0]      pixel_x,
    output logic [nbrd_pkg::BYTE_W-1:0]      pixel_y,
    output logic [nbrd_pkg::COLOR_W-1:0]     color_code,
    output logic [nbrd_pkg::BYTE_W-1:0]      red,
    output logic [nbrd_pkg::BYTE_W-1:0]      green,
    output logic [nbrd_pkg::BYTE_W-1:0]      blue,
    output logic                             last_pixel
);

    localparam int TW = nbrd_pkg::TILE_W;
    localparam int SW = nbrd_pkg::SUB_W;
    localparam int BW = nbrd_pkg::BYTE_W;
    localparam int CW = nbrd_pkg::COLOR_W;

    // Palette registers
    logic [nbrd_pkg::PAL_W-1:0] pal_low_reg;
    logic [nbrd_pkg::PAL_W-1:0] pal_high_reg;

    // Row register
    logic          row_valid_reg, row_valid_next;
    logic [SW-1:0] pix_cnt_reg, pix_cnt_next;
    logic [TW-1:0] col_reg;
    logic [BW-1:0] y_reg;
    logic [BW-1:0] lo_reg;
    logic [BW-1:0] hi_reg;
    logic [1:0]    attr_reg;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [BW-1:0] x_out_reg;
    logic [BW-1:0] y_out_reg;
    logic [CW-1:0] color_out_reg;
    logic [nbrd_pkg::RGB_W-1:0] rgb_out_reg;
    logic          last_out_reg;

    logic          advance;
    logic          row_done;
    logic          in_take;
    logic          in_range;
    logic [1:0]    attr_sel;
    logic [SW-1:0] bit_pos;
    logic [3:0]    pal_idx;
    logic [5:0]    pal_shift;
    logic [nbrd_pkg::PAL_W-1:0] pal_bank;
    logic [CW-1:0] color_sel;

    // Write palette registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_low_reg  <= '0;
            pal_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nbrd_pkg::REG_PALETTE_LOW:  pal_low_reg  <= cfg_data;
                nbrd_pkg::REG_PALETTE_HIGH: pal_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: advance a pixel when the output register is free
    assign advance  = row_valid_reg && (!out_valid_reg || out_ready);
    assign row_done = advance && (pix_cnt_reg == {SW{1'b1}});
    assign in_ready = !row_valid_reg || row_done;
    assign in_take  = in_valid && in_ready;
    assign in_range = ({1'b0, tile_column} < (TW+1)'(nbrd_pkg::TILES_WIDE))
                   && ({1'b0, tile_row} < (TW+1)'(nbrd_pkg::TILES_HIGH));

    // Pick the attribute quadrant from tile coordinate bit 1
    assign attr_sel = attribute_byte[{tile_row[1], tile_column[1], 1'b0} +: 2];

    // Next state of row register and output valid
    always_comb
    begin
        row_valid_next = row_valid_reg;
        pix_cnt_next   = pix_cnt_reg;
        if (in_take)
        begin
            row_valid_next = in_range;
            pix_cnt_next   = '0;
        end
        else if (advance)
        begin
            pix_cnt_next = pix_cnt_reg + SW'(1);
            if (row_done)
            begin
                row_valid_next = 1'b0;
            end
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
            pix_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            pix_cnt_reg   <= pix_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load row payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            col_reg  <= tile_column;
            y_reg    <= {tile_row, row_in_tile};
            lo_reg   <= plane_low_byte;
            hi_reg   <= plane_high_byte;
            attr_reg <= attr_sel;
        end
    end

    // Form the palette index for the current pixel, leftmost bit first
    assign bit_pos   = ~pix_cnt_reg;
    assign pal_idx   = {attr_reg, hi_reg[bit_pos], lo_reg[bit_pos]};
    assign pal_bank  = pal_idx[3] ? pal_high_reg : pal_low_reg;
    // entry offset is six times the entry number: 4x plus 2x
    assign pal_shift = {1'b0, pal_idx[2:0], 2'b00} + {2'b00, pal_idx[2:0], 1'b0};
    assign color_sel = pal_bank[pal_shift +: CW];

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_out_reg     <= {col_reg, pix_cnt_reg};
            y_out_reg     <= y_reg;
            color_out_reg <= color_sel;
            rgb_out_reg   <= nbrd_pkg::NTSC_RGB[color_sel];
            last_out_reg  <= (pix_cnt_reg == {SW{1'b1}});
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = x_out_reg;
    assign pixel_y    = y_out_reg;
    assign color_code = color_out_reg;
    assign red        = rgb_out_reg[23:16];
    assign green      = rgb_out_reg[15:8];
    assign blue       = rgb_out_reg[7:0];
    assign last_pixel = last_out_reg;

endmodule

/* dv/nes_background_row_decode_tb.sv */
// Testbench for the background row decoder: drives tile rows and palette
// writes, predicts the eight pixel words of each on-screen row and checks them in order.
// Depends on nbrd_pkg and nes_background_row_decode.
`timescale 1ns / 100ps

typedef struct packed {
    logic [4:0] column;
    logic [4:0] tile_y;
    logic [2:0] sub_row;
    logic [7:0] plane_lo;
    logic [7:0] plane_hi;
    logic [7:0] attr;
} tile_row_t;

typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [5:0] cid;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
} pixel_t;

class pixel_board;
    pixel_t      pixels_due[$];
    logic [47:0] pal_lo;
    logic [47:0] pal_hi;
    logic [23:0] rgb_of [64];
    int          errors;

    function new();
        pal_lo = '0;
        pal_hi = '0;
        errors = 0;
        rgb_of = '{
            24'h808080, 24'h003DA6, 24'h0012B0, 24'h440096,
            24'hA1005E, 24'hC70028, 24'hBA0600, 24'h8C1700,
            24'h5C2F00, 24'h104500, 24'h054A00, 24'h00472E,
            24'h004166, 24'h000000, 24'h050505, 24'h050505,
            24'hC7C7C7, 24'h0077FF, 24'h2155FF, 24'h8237FA,
            24'hEB2FB5, 24'hFF2950, 24'hFF2200, 24'hD63200,
            24'hC46200, 24'h358000, 24'h058F00, 24'h008A55,
            24'h0099CC, 24'h212121, 24'h090909, 24'h090909,
            24'hFFFFFF, 24'h0FD7FF, 24'h69A2FF, 24'hD480FF,
            24'hFF45F3, 24'hFF618B, 24'hFF8833, 24'hFF9C12,
            24'hFABC20, 24'h9FE30E, 24'h2BF035, 24'h0CF0A4,
            24'h05FBFF, 24'h5E5E5E, 24'h0D0D0D, 24'h0D0D0D,
            24'hFFFFFF, 24'hA6FCFF, 24'hB3ECFF, 24'hDAABEB,
            24'hFFA8F9, 24'hFFABB3, 24'hFFD2B0, 24'hFFEFA6,
            24'hFFF79C, 24'hD7E895, 24'hA6EDAF, 24'hA2F2DA,
            24'h99FFFC, 24'hDDDDDD, 24'h111111, 24'h111111
        };
    endfunction

    function void set_palette(input logic [nbrd_pkg::REGIDX_W-1:0] idx,
                              input logic [47:0] data);
        if (idx == nbrd_pkg::REG_PALETTE_LOW)
            pal_lo = data;
        else
            pal_hi = data;
    endfunction

    // Decode one accepted row into its eight expected pixel words
    function void note_row(input tile_row_t t);
        pixel_t      p;
        logic [1:0]  attr_sel;
        logic [3:0]  pal_idx;
        logic [47:0] bank;
        int          k;
        // rows outside the nametable produce nothing
        if (t.column >= nbrd_pkg::TILES_WIDE || t.tile_y >= nbrd_pkg::TILES_HIGH)
            return;
        attr_sel = 2'(t.attr >> {t.tile_y[1], t.column[1], 1'b0});
        for (k = 0; k < 8; k++)
        begin
            pal_idx = {attr_sel, t.plane_hi[7-k], t.plane_lo[7-k]};
            bank = pal_idx[3] ? pal_hi : pal_lo;
            p.x = {t.column, 3'b000} + 8'(k);
            p.y = {t.tile_y, 3'b000} + {5'b0, t.sub_row};
            p.cid = bank[pal_idx[2:0]*6 +: 6];
            {p.r, p.g, p.b} = rgb_of[p.cid];
            p.last = (k == 7);
            pixels_due = {pixels_due, p};
        end
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Compare one accepted pixel word with the oldest expected one
    function void check_pixel(input pixel_t got);
        pixel_t want;
        if (pixels_due.size() == 0)
        begin
            $error("pixel word with nothing pending: x=%0d y=%0d", got.x, got.y);
            errors++;
            return;
        end
        want = pixels_due.pop_front();
        compare_field("pixel_x", want.x, got.x);
        compare_field("pixel_y", want.y, got.y);
        compare_field("color_code", want.cid, got.cid);
        compare_field("red", want.r, got.r);
        compare_field("green", want.g, got.g);
        compare_field("blue", want.b, got.b);
        compare_field("last_pixel", want.last, got.last);
    endfunction
endclass

module nes_background_row_decode_tb;

    localparam int SETTLE_CYCLES = 16;
    localparam int ROWS_PER_PHASE = 32;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [nbrd_pkg::REGIDX_W-1:0]   cfg_index;
    logic [nbrd_pkg::PAL_W-1:0]      cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    tile_row_t                       drive_row;
    logic                            out_valid;
    logic                            out_ready;
    logic [7:0]                      pixel_x;
    logic [7:0]                      pixel_y;
    logic [5:0]                      color_code;
    logic [7:0]                      red;
    logic [7:0]                      green;
    logic [7:0]                      blue;
    logic                            last_pixel;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    pixel_board  board;

    nes_background_row_decode dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .tile_column     (drive_row.column),
        .tile_row        (drive_row.tile_y),
        .row_in_tile     (drive_row.sub_row),
        .plane_low_byte  (drive_row.plane_lo),
        .plane_high_byte (drive_row.plane_hi),
        .attribute_byte  (drive_row.attr),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .color_code      (color_code),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .last_pixel      (last_pixel)
    );

    always #6 clk = ~clk;

    function automatic tile_row_t make_row(input logic [4:0] column, input logic [4:0] tile_y,
                                           input logic [2:0] sub_row, input logic [7:0] lo,
                                           input logic [7:0] hi, input logic [7:0] attr);
        tile_row_t t;
        t.column = column;
        t.tile_y = tile_y;
        t.sub_row = sub_row;
        t.plane_lo = lo;
        t.plane_hi = hi;
        t.attr = attr;
        return t;
    endfunction

    function automatic tile_row_t random_row(input bit on_screen);
        tile_row_t t;
        t = tile_row_t'(37'({$urandom(), $urandom()}));
        if (on_screen)
            t.tile_y = 5'($urandom_range(nbrd_pkg::TILES_HIGH - 1));
        else
            t.tile_y = 5'($urandom_range(31, nbrd_pkg::TILES_HIGH));
        return t;
    endfunction

    function automatic logic [47:0] random_palette();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Offer one row word, idling first at random, and hold it until taken
    task automatic send_row(input tile_row_t t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            drive_row <= tile_row_t'(37'({$urandom(), $urandom()}));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        drive_row <= t;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_row(t);
    endtask

    task automatic write_palette(input logic [nbrd_pkg::REGIDX_W-1:0] idx,
                                 input logic [47:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        board.set_palette(idx, data);
    endtask

    // Stop sending, wait for every pending pixel, then let the pipe go quiet
    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pixel receiver: stall at random, check each accepted word
    initial
    begin
        pixel_t seen;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                seen = {pixel_x, pixel_y, color_code, red, green, blue, last_pixel};
                board.check_pixel(seen);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        tile_row_t t;
        int        phase;
        int        sent;
        logic [47:0] lo_val;
        logic [47:0] hi_val;

        board = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = nbrd_pkg::REG_PALETTE_LOW;
        cfg_data = '0;
        in_valid = 1'b0;
        drive_row = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Rows under the reset palette
        send_row(make_row(5'd4, 5'd6, 3'd2, 8'hC3, 8'h5A, 8'h1B));
        send_row(make_row(5'd31, 5'd29, 3'd7, 8'hFF, 8'h00, 8'hFF));
        drain_outputs();

        // Directed rows: field extremes, each attribute quadrant, plane patterns
        write_palette(nbrd_pkg::REG_PALETTE_LOW, random_palette());
        write_palette(nbrd_pkg::REG_PALETTE_HIGH, random_palette());
        send_row(make_row(5'd0, 5'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        send_row(make_row(5'd31, 5'd29, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_row(make_row(5'd0, 5'd0, 3'd3, 8'hAA, 8'h55, 8'hE4));
        send_row(make_row(5'd2, 5'd0, 3'd3, 8'h55, 8'hAA, 8'hE4));
        send_row(make_row(5'd0, 5'd2, 3'd3, 8'hF0, 8'h0F, 8'hE4));
        send_row(make_row(5'd2, 5'd2, 3'd3, 8'h0F, 8'hF0, 8'hE4));
        send_row(make_row(5'd1, 5'd1, 3'd5, 8'h80, 8'h01, 8'h1B));
        send_row(make_row(5'd3, 5'd3, 3'd6, 8'h01, 8'h80, 8'h1B));
        send_row(make_row(5'd31, 5'd30, 3'd1, 8'hFF, 8'hFF, 8'hFF));
        send_row(make_row(5'd17, 5'd12, 3'd4, 8'h3C, 8'hC3, 8'h93));
        send_row(make_row(5'd0, 5'd31, 3'd7, 8'h12, 8'h34, 8'h56));
        send_row(make_row(5'd30, 5'd28, 3'd0, 8'hFF, 8'h00, 8'hAA));
        send_row(make_row(5'd29, 5'd1, 3'd7, 8'h00, 8'hFF, 8'h55));
        send_row(make_row(5'd31, 5'd0, 3'd0, 8'h00, 8'h00, 8'hFF));
        send_row(make_row(5'd0, 5'd29, 3'd7, 8'hFF, 8'hFF, 8'h00));
        drain_outputs();

        // Random phases: rotate idling modes and palette settings
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            case (phase)
                1:
                begin
                    lo_val = '1;
                    hi_val = '1;
                end
                2:
                begin
                    lo_val = '0;
                    hi_val = '0;
                end
                5:
                begin
                    lo_val = '1;
                    hi_val = '0;
                end
                default:
                begin
                    lo_val = random_palette();
                    hi_val = random_palette();
                end
            endcase
            write_palette(nbrd_pkg::REG_PALETTE_LOW, lo_val);
            write_palette(nbrd_pkg::REG_PALETTE_HIGH, hi_val);
            sent = 0;
            while (sent < ROWS_PER_PHASE)
            begin
                if ($urandom_range(99) < 15)
                begin
                    t = random_row(1'b0);
                end
                else
                begin
                    t = random_row(1'b1);
                    sent++;
                end
                send_row(t);
            end
            drain_outputs();
        end

        if (board.errors == 0 && board.pixels_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
